// File: design/smoothed_differential_drive_mixer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed differential drive mixer
// Shared property wrappers. Each one is clocked on clk and is held off while
// rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_DIFFERENTIAL_DRIVE_MIXER_CORE_ASSERT_SVH
`define SMOOTHED_DIFFERENTIAL_DRIVE_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/sdm_pkg.sv
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the differential drive mixer
// Word layouts, register indexes, event codes and reset values.
// ----------------------------------------------------------------------------
package sdm_pkg;

    localparam int MODE_W     = 2;
    localparam int AXIS_W     = 8;
    localparam int DUTY_W     = 7;
    localparam int GAIN_W     = 9;
    localparam int CFG7_W     = 7;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    localparam int FRAC_BITS_DEFAULT  = 8;
    localparam int FULL_SCALE_DEFAULT = 100;

    // Event codes carried in the mode field.
    localparam logic [MODE_W-1:0] MODE_STEER    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE  = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DELTA    = 2'd3;

    // Reset values of the registers.
    localparam logic [GAIN_W-1:0] GAIN_RESET     = 9'd51;
    localparam logic [CFG7_W-1:0] DEADZONE_RESET = 7'd5;
    localparam logic [CFG7_W-1:0] FLOOR_RESET    = 7'd2;
    localparam logic [CFG7_W-1:0] DELTA_RESET    = 7'd1;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [AXIS_W-1:0] axis_value;
    } cmd_word_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_left;
        logic [DUTY_W-1:0] duty_right;
        logic              duty_updated;
        logic              dir_left;
        logic              dir_right;
        logic              dir_changed;
    } res_word_t;

    typedef struct packed {
        logic [GAIN_W-1:0] smoothing_gain_q8;
        logic [CFG7_W-1:0] steer_deadzone;
        logic [CFG7_W-1:0] throttle_floor;
        logic [CFG7_W-1:0] update_delta;
    } cfg_t;

endpackage

// File: design/sdm_cfg_regs.sv
// ----------------------------------------------------------------------------
// sdm_cfg_regs: configuration register file
// Four write-only registers loaded by index from the write port.
// ----------------------------------------------------------------------------
module sdm_cfg_regs
    import sdm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_GAIN:     cfg_next.smoothing_gain_q8 = cfg_data;
                REG_DEADZONE: cfg_next.steer_deadzone = cfg_data[CFG7_W-1:0];
                REG_FLOOR:    cfg_next.throttle_floor = cfg_data[CFG7_W-1:0];
                REG_DELTA:    cfg_next.update_delta = cfg_data[CFG7_W-1:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing_gain_q8 <= GAIN_RESET;
            cfg_reg.steer_deadzone    <= DEADZONE_RESET;
            cfg_reg.throttle_floor    <= FLOOR_RESET;
            cfg_reg.update_delta      <= DELTA_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/sdm_mul.sv
// ----------------------------------------------------------------------------
// sdm_mul: shared signed multiplier
// One signed multiply with a registered product, loaded when enabled.
// ----------------------------------------------------------------------------
module sdm_mul
    import sdm_pkg::*;
#(
    parameter int OP_W = 18
)
(
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [OP_W-1:0]     a,
    input  logic signed [OP_W-1:0]     b,
    output logic signed [2*OP_W-1:0]   p
);

    logic signed [2*OP_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule

// File: design/smoothed_differential_drive_mixer_core.sv
// ----------------------------------------------------------------------------
// smoothed_differential_drive_mixer_core: skid-steer duty mixer
// Smooths steering and throttle events and mixes them into left/right duties.
// ----------------------------------------------------------------------------
// Each command word is one controller event. A steering word is saturated to
// +/-FULL_SCALE, deadzoned and folded into an exponential moving average; a
// throttle word either zeroes the throttle (below throttle_floor) or is folded
// into its own average. The smoothed throttle then feeds the outer wheel, and
// the inner wheel gets throttle * (1 - |steer| / FULL_SCALE). New duties are
// latched only when steering or throttle has moved by more than update_delta
// since the last latched pair. A reverse word flips the direction pins only
// while the smoothed throttle sits below throttle_floor. Every command word
// yields exactly one result word. All arithmetic runs through one registered
// multiplier under a small sequencer: g*raw, (1-g)*old, throttle*margin, and a
// reciprocal multiply that replaces the divide by FULL_SCALE. An axis word
// whose average is updated steps through EMA_G, EMA_OLD, EMA_SUM, MIX_TM,
// MIX_Q and FIN; a throttle word below the floor goes to MIX_TM, MIX_Q and FIN,
// and a reverse or unused word straight to FIN. FIN registers the result once
// the output register is free, and cmd_ready is high only in IDLE. A waiting
// result word lets the next command word be taken, but holds it in FIN.
// ----------------------------------------------------------------------------
module smoothed_differential_drive_mixer_core
    import sdm_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    parameter int FULL_SCALE = FULL_SCALE_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  cmd_word_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_word_t             res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Fixed-point geometry. Steering state is signed Q.FRAC_BITS within
    // +/-FULL_SCALE, throttle state unsigned Q.FRAC_BITS within [0, FULL_SCALE].
    localparam longint ONE_Q   = longint'(1) << FRAC_BITS;
    localparam longint FULL_Q  = longint'(FULL_SCALE) * ONE_Q;
    localparam int     FS_W    = $clog2(FULL_SCALE + 1);
    localparam int     RAW_W   = ((FS_W > AXIS_W) ? FS_W : AXIS_W) + 1;
    localparam int     GW      = FRAC_BITS + 1;
    localparam int     GCW     = (GAIN_W > GW) ? GAIN_W : GW;
    localparam int     T_W     = $clog2(FULL_Q + 1);
    localparam int     S_W     = T_W + 1;
    localparam int     SUM_W   = S_W + FRAC_BITS + 2;

    // The inner duty is floor(floor(T*M / 2^(2F)) / FULL_SCALE). The second
    // divide is a multiply by a rounded-up reciprocal that is exact for every
    // quotient below 2^QW.
    localparam int     QW      = $clog2(FULL_SCALE * FULL_SCALE + 1);
    localparam int     LW      = $clog2(FULL_SCALE);
    localparam int     RSH     = QW + LW;
    localparam longint RECIP   = ((longint'(1) << RSH) + FULL_SCALE - 1) / FULL_SCALE;
    localparam int     RECIP_W = $clog2(RECIP + 1);

    // Operand width of the shared multiplier: wide enough for every product.
    localparam int     OW1     = (GW + 1 > RAW_W) ? GW + 1 : RAW_W;
    localparam int     OW2     = (OW1 > S_W) ? OW1 : S_W;
    localparam int     OW3     = (OW2 > QW + 1) ? OW2 : QW + 1;
    localparam int     OW4     = (OW3 > RECIP_W + 1) ? OW3 : RECIP_W + 1;
    localparam int     OP_W    = (OW4 > (RSH + DUTY_W + 1) / 2) ? OW4
                                 : (RSH + DUTY_W + 1) / 2;

    localparam int     DW      = S_W + FRAC_BITS + CFG7_W;
    localparam int     FLW     = T_W + FRAC_BITS + CFG7_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_EMA_G   = 3'd1;
    localparam logic [2:0] ST_EMA_OLD = 3'd2;
    localparam logic [2:0] ST_EMA_SUM = 3'd3;
    localparam logic [2:0] ST_MIX_TM  = 3'd4;
    localparam logic [2:0] ST_MIX_Q   = 3'd5;
    localparam logic [2:0] ST_FIN     = 3'd6;

    cfg_t cfg;

    sdm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    logic                     mul_en;
    logic signed [OP_W-1:0]   mul_a;
    logic signed [OP_W-1:0]   mul_b;
    logic signed [2*OP_W-1:0] mul_p;

    sdm_mul #(
        .OP_W (OP_W)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // Control state.
    logic [2:0]  state_reg, state_next;
    logic        res_valid_reg, res_valid_next;

    // Smoothing and hold state.
    logic signed [S_W-1:0] steer_reg, steer_next;
    logic [T_W-1:0]        thr_reg, thr_next;
    logic signed [S_W-1:0] steer_app_reg, steer_app_next;
    logic [T_W-1:0]        thr_app_reg, thr_app_next;
    logic [DUTY_W-1:0]     duty_l_reg, duty_l_next;
    logic [DUTY_W-1:0]     duty_r_reg, duty_r_next;
    logic                  rev_reg, rev_next;

    // Per-word working registers.
    logic [MODE_W-1:0]       mode_reg, mode_next;
    logic signed [RAW_W-1:0] raw_reg, raw_next;
    logic signed [SUM_W-1:0] acc_reg, acc_next;
    res_word_t               res_reg, res_next;

    // Input preparation.
    logic signed [RAW_W-1:0] raw_ext;
    logic signed [RAW_W-1:0] fs_s;
    logic signed [RAW_W-1:0] dz_s;
    logic signed [RAW_W-1:0] floor_s;
    logic signed [RAW_W-1:0] steer_clamp;
    logic signed [RAW_W-1:0] steer_mag;
    logic signed [RAW_W-1:0] steer_prep;
    logic signed [RAW_W-1:0] thr_prep;
    logic                    thr_below;

    // Arithmetic helpers.
    logic [GW-1:0]           g_eff;
    logic [GW-1:0]           g_rest;
    logic signed [SUM_W-1:0] ema_sum;
    logic signed [SUM_W-1:0] ema_adj;
    logic signed [SUM_W-1:0] ema_q;
    logic signed [S_W:0]     margin_s;
    logic [T_W-1:0]          margin;
    logic [S_W-1:0]          steer_abs;
    logic [QW-1:0]           quot;
    logic [DUTY_W-1:0]       inner;
    logic [DUTY_W-1:0]       outer;
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic signed [S_W:0]     steer_diff;
    logic signed [T_W:0]     thr_diff;
    logic [DW-1:0]           steer_dev;
    logic [DW-1:0]           thr_dev;
    logic [DW-1:0]           delta_q;
    logic                    moved;
    logic                    rev_allowed;
    logic                    slot_free;

    always_comb
    begin
        raw_ext     = RAW_W'(cmd.axis_value);
        fs_s        = RAW_W'(FULL_SCALE);
        dz_s        = RAW_W'(cfg.steer_deadzone);
        floor_s     = RAW_W'(cfg.throttle_floor);

        // Steering: saturate, then deadzone on the magnitude.
        if (raw_ext > fs_s)
        begin
            steer_clamp = fs_s;
        end
        else if (raw_ext < -fs_s)
        begin
            steer_clamp = -fs_s;
        end
        else
        begin
            steer_clamp = raw_ext;
        end
        steer_mag  = steer_clamp[RAW_W-1] ? -steer_clamp : steer_clamp;
        steer_prep = (steer_mag < dz_s) ? '0 : steer_clamp;

        // Throttle: the floor test sees the raw value, saturation comes after.
        thr_below = raw_ext < floor_s;
        thr_prep  = (raw_ext > fs_s) ? fs_s : raw_ext;
    end

    always_comb
    begin
        // Gains above unity saturate to unity.
        g_eff  = (GCW'(cfg.smoothing_gain_q8) > GCW'(ONE_Q)) ? GW'(ONE_Q)
                 : GW'(cfg.smoothing_gain_q8);
        g_rest = GW'(ONE_Q) - g_eff;

        // EMA sum; the shift toward zero needs a bias on negative sums.
        ema_sum = (acc_reg <<< FRAC_BITS) + SUM_W'(mul_p);
        ema_adj = ema_sum[SUM_W-1] ? ema_sum + SUM_W'(ONE_Q - 1) : ema_sum;
        ema_q   = ema_adj >>> FRAC_BITS;

        // Inner-wheel margin: FULL_Q - |steer|, never negative.
        steer_abs = steer_reg[S_W-1] ? S_W'(-steer_reg) : S_W'(steer_reg);
        margin_s  = (S_W+1)'(FULL_Q) - $signed({1'b0, steer_abs});
        margin    = margin_s[S_W] ? '0 : T_W'(margin_s);

        quot  = mul_p[2*FRAC_BITS +: QW];
        inner = mul_p[RSH +: DUTY_W];
        outer = DUTY_W'(thr_reg >> FRAC_BITS);

        left_duty  = outer;
        right_duty = outer;
        if (steer_reg < 0)
        begin
            left_duty = inner;
        end
        else if (steer_reg > 0)
        begin
            right_duty = inner;
        end

        // Change detection against the last latched pair.
        steer_diff = (S_W+1)'(steer_reg) - (S_W+1)'(steer_app_reg);
        thr_diff   = $signed({1'b0, thr_reg}) - $signed({1'b0, thr_app_reg});
        steer_dev  = steer_diff[S_W] ? DW'(-steer_diff) : DW'(steer_diff);
        thr_dev    = thr_diff[T_W] ? DW'(-thr_diff) : DW'(thr_diff);
        delta_q    = DW'(cfg.update_delta) << FRAC_BITS;
        moved      = (steer_dev > delta_q) || (thr_dev > delta_q);

        rev_allowed = FLW'(thr_reg) < (FLW'(cfg.throttle_floor) << FRAC_BITS);
        slot_free   = !res_valid_reg || res_ready;
    end

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg;
        steer_next     = steer_reg;
        thr_next       = thr_reg;
        steer_app_next = steer_app_reg;
        thr_app_next   = thr_app_reg;
        duty_l_next    = duty_l_reg;
        duty_r_next    = duty_r_reg;
        rev_next       = rev_reg;
        mode_next      = mode_reg;
        raw_next       = raw_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    mode_next = cmd.mode;
                    if (cmd.mode == MODE_STEER)
                    begin
                        raw_next   = steer_prep;
                        state_next = ST_EMA_G;
                    end
                    else if (cmd.mode == MODE_THROTTLE)
                    begin
                        raw_next = thr_prep;
                        if (thr_below)
                        begin
                            thr_next   = '0;
                            state_next = ST_MIX_TM;
                        end
                        else
                        begin
                            state_next = ST_EMA_G;
                        end
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_EMA_G:
            begin
                mul_en     = 1'b1;
                mul_a      = OP_W'(g_eff);
                mul_b      = OP_W'(raw_reg);
                state_next = ST_EMA_OLD;
            end

            ST_EMA_OLD:
            begin
                mul_en   = 1'b1;
                mul_a    = OP_W'(g_rest);
                acc_next = SUM_W'(mul_p);
                if (mode_reg == MODE_STEER)
                begin
                    mul_b = OP_W'(steer_reg);
                end
                else
                begin
                    mul_b = OP_W'(thr_reg);
                end
                state_next = ST_EMA_SUM;
            end

            ST_EMA_SUM:
            begin
                if (mode_reg == MODE_STEER)
                begin
                    steer_next = S_W'(ema_q);
                end
                else
                begin
                    thr_next = T_W'(ema_q);
                end
                state_next = ST_MIX_TM;
            end

            ST_MIX_TM:
            begin
                mul_en     = 1'b1;
                mul_a      = OP_W'(thr_reg);
                mul_b      = OP_W'(margin);
                state_next = ST_MIX_Q;
            end

            ST_MIX_Q:
            begin
                mul_en     = 1'b1;
                mul_a      = OP_W'(quot);
                mul_b      = OP_W'(RECIP);
                state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (slot_free)
                begin
                    res_next.duty_updated = 1'b0;
                    res_next.dir_changed  = 1'b0;
                    res_next.duty_left    = duty_l_reg;
                    res_next.duty_right   = duty_r_reg;
                    res_next.dir_left     = !rev_reg;
                    res_next.dir_right    = rev_reg;
                    if ((mode_reg == MODE_STEER) || (mode_reg == MODE_THROTTLE))
                    begin
                        if (moved)
                        begin
                            duty_l_next           = left_duty;
                            duty_r_next           = right_duty;
                            steer_app_next        = steer_reg;
                            thr_app_next          = thr_reg;
                            res_next.duty_left    = left_duty;
                            res_next.duty_right   = right_duty;
                            res_next.duty_updated = 1'b1;
                        end
                    end
                    else if ((mode_reg == MODE_REVERSE) && rev_allowed)
                    begin
                        rev_next             = !rev_reg;
                        res_next.dir_left    = rev_reg;
                        res_next.dir_right   = !rev_reg;
                        res_next.dir_changed = 1'b1;
                    end
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            steer_reg     <= '0;
            thr_reg       <= '0;
            steer_app_reg <= '0;
            thr_app_reg   <= '0;
            duty_l_reg    <= '0;
            duty_r_reg    <= '0;
            rev_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            steer_reg     <= steer_next;
            thr_reg       <= thr_next;
            steer_app_reg <= steer_app_next;
            thr_app_reg   <= thr_app_next;
            duty_l_reg    <= duty_l_next;
            duty_r_reg    <= duty_r_next;
            rev_reg       <= rev_next;
        end
    end

    // Working registers carry no reset: each is written before it is read.
    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        raw_reg  <= raw_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: design/sdm_checker.sv
// ----------------------------------------------------------------------------
// sdm_checker: port-level checks for the differential drive mixer
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
`include "smoothed_differential_drive_mixer_core_assert.svh"

module sdm_checker
    import sdm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_valid,
    input logic      cmd_ready,
    input cmd_word_t cmd,
    input logic      res_valid,
    input logic      res_ready,
    input res_word_t res
);

    // A stalled result word stays put.
`SDM_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res), "result word changed while stalled")

    // Every event moves the sequencer out of IDLE, so the block is busy after a take.
`SDM_ASSERT_NEXT(a_busy_after_take, cmd_valid && cmd_ready, !cmd_ready, "command taken twice in a row")

    // The two direction pins always point opposite ways.
`SDM_ASSERT_SAME(a_dir_opposed, res_valid, res.dir_left != res.dir_right, "direction pins not complementary")

    // A word either moves duties or flips direction, never both.
`SDM_ASSERT_SAME(a_one_effect, res_valid, !(res.duty_updated && res.dir_changed), "duty update and direction change in one word")

endmodule

bind smoothed_differential_drive_mixer_core sdm_checker u_sdm_checker (.*);

// File: test/smoothed_differential_drive_mixer_core_tb.sv
// ----------------------------------------------------------------------------
// Testbench for smoothed_differential_drive_mixer_core
// Sends steering, throttle, reverse and spare event words through the command
// channel and checks every result word against a cycle-free predictor of the
// smoothing, mixing, update gating and direction logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smoothed_differential_drive_mixer_core_tb;
    import sdm_pkg::*;

    // The package names the three live event codes. Code 3 is unused by the
    // block, but it still has to answer with the held state.
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Fixed-point constants of the default build.
    localparam longint ONE_Q  = longint'(1) << FRAC_BITS_DEFAULT;
    localparam longint FULL_Q = longint'(FULL_SCALE_DEFAULT) * ONE_Q;

    // Idle stretches after the last result word: the settle pause before register
    // writes and the tail at the end.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Cycles without any accepted word before the run is declared hung. The
    // longest legal quiet stretch is the forced receiver hold-off plus a gap.
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_OFF_LEN  = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  cmd_valid;
    logic                  cmd_ready;
    cmd_word_t             cmd;
    logic                  res_valid;
    logic                  res_ready;
    res_word_t             res;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the block's registers and state, kept by the predictor.
    int     gain_reg;
    int     deadzone_reg;
    int     floor_reg;
    int     delta_reg;
    longint steer_avg;
    longint throttle_avg;
    longint steer_latched;
    longint throttle_latched;
    int     left_duty_held;
    int     right_duty_held;
    bit     reversed;

    // Result words predicted for accepted events, oldest first.
    res_word_t duty_words_due[$];

    int mismatch_count;
    int quiet_cycles;
    bit tx_idle_en;
    bit rx_idle_en;
    int rx_hold_req;

    smoothed_differential_drive_mixer_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Exponential moving average in Q8: the gain saturates at unity and the
    // divide truncates toward zero, which is what SystemVerilog's signed
    // division does as well.
    function automatic longint ema_step(longint prev, longint sample);
        longint g;
        longint acc;
        g = (gain_reg > ONE_Q) ? ONE_Q : longint'(gain_reg);
        acc = g * (sample * ONE_Q) + (ONE_Q - g) * prev;
        return acc / ONE_Q;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Works out the result word of one event and advances the shadow state.
    function automatic res_word_t mix_event(cmd_word_t w);
        longint    sample;
        longint    step_q;
        longint    margin;
        int        outer_duty;
        int        inner_duty;
        int        left;
        int        right;
        bit        applied;
        bit        flipped;
        res_word_t r;

        sample  = longint'($signed(w.axis_value));
        applied = 1'b0;
        flipped = 1'b0;

        if (w.mode == MODE_STEER || w.mode == MODE_THROTTLE)
        begin
            if (w.mode == MODE_STEER)
            begin
                // Saturate first, then apply the deadzone.
                if (sample > FULL_SCALE_DEFAULT)
                    sample = FULL_SCALE_DEFAULT;
                if (sample < -FULL_SCALE_DEFAULT)
                    sample = -FULL_SCALE_DEFAULT;
                if (mag(sample) < deadzone_reg)
                    sample = 0;
                steer_avg = ema_step(steer_avg, sample);
            end
            else if (sample < floor_reg)
            begin
                // The floor test sees the raw value, before saturation.
                throttle_avg = 0;
            end
            else
            begin
                if (sample > FULL_SCALE_DEFAULT)
                    sample = FULL_SCALE_DEFAULT;
                throttle_avg = ema_step(throttle_avg, sample);
            end

            outer_duty = int'(throttle_avg / ONE_Q);
            margin = FULL_Q - mag(steer_avg);
            if (margin < 0)
                margin = 0;
            inner_duty = int'((throttle_avg * margin) / (FULL_Q * ONE_Q));

            // The wheel on the side of the turn gets the scaled duty.
            left  = outer_duty;
            right = outer_duty;
            if (steer_avg < 0)
                left = inner_duty;
            else if (steer_avg > 0)
                right = inner_duty;

            step_q = longint'(delta_reg) * ONE_Q;
            if (mag(steer_avg - steer_latched) > step_q ||
                mag(throttle_avg - throttle_latched) > step_q)
            begin
                left_duty_held   = left & 'h7F;
                right_duty_held  = right & 'h7F;
                steer_latched    = steer_avg;
                throttle_latched = throttle_avg;
                applied          = 1'b1;
            end
        end
        else if (w.mode == MODE_REVERSE)
        begin
            // Direction may only flip while the drive is close to standstill.
            if (throttle_avg < longint'(floor_reg) * ONE_Q)
            begin
                reversed = ~reversed;
                flipped  = 1'b1;
            end
        end

        r.duty_left    = left_duty_held[DUTY_W-1:0];
        r.duty_right   = right_duty_held[DUTY_W-1:0];
        r.duty_updated = applied;
        r.dir_left     = ~reversed;
        r.dir_right    = reversed;
        r.dir_changed  = flipped;
        return r;
    endfunction

    task automatic reset_model();
        gain_reg         = GAIN_RESET;
        deadzone_reg     = DEADZONE_RESET;
        floor_reg        = FLOOR_RESET;
        delta_reg        = DELTA_RESET;
        steer_avg        = 0;
        throttle_avg     = 0;
        steer_latched    = 0;
        throttle_latched = 0;
        left_duty_held   = 0;
        right_duty_held  = 0;
        reversed         = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    // Mostly back-to-back, sometimes a short pause, now and then a long one.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic cmd_word_t make_cmd(logic [MODE_W-1:0] kind, int value);
        cmd_word_t w;
        w.mode       = kind;
        w.axis_value = value[AXIS_W-1:0];
        return w;
    endfunction

    // Offers one event word and returns at the edge that accepts it. Valid is
    // left high so that a following word can follow without a bubble; the
    // next call or the next idle stretch lowers it.
    task automatic send_event(cmd_word_t w);
        int gap;
        gap = tx_idle_en ? idle_gap() : 0;
        repeat (gap) @(negedge clk) cmd_valid <= 1'b0;
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (!cmd_ready);
        duty_words_due.push_back(mix_event(w));
    endtask

    // Waits until every expected word has come back and the block is idle.
    task automatic settle();
        @(negedge clk) cmd_valid <= 1'b0;
        while (duty_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers, one per cycle, while the block is idle.
    task automatic program_regs(int gain, int deadzone, int floor_lvl, int delta);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN;
        cfg_data  <= gain[CFG_DATA_W-1:0];
        gain_reg   = gain & 'h1FF;
        @(negedge clk);
        cfg_index <= REG_DEADZONE;
        cfg_data  <= deadzone[CFG_DATA_W-1:0];
        deadzone_reg = deadzone & 'h7F;
        @(negedge clk);
        cfg_index <= REG_FLOOR;
        cfg_data  <= floor_lvl[CFG_DATA_W-1:0];
        floor_reg  = floor_lvl & 'h7F;
        @(negedge clk);
        cfg_index <= REG_DELTA;
        cfg_data  <= delta[CFG_DATA_W-1:0];
        delta_reg  = delta & 'h7F;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A random event. Most of them are in-range axis samples, so that the
    // averages wander through the whole range and the update gate opens and
    // closes. Low throttle values bring the drive back to standstill often
    // enough for reverse presses to be taken. The rest is noise: raw bytes
    // outside the axis range and the spare code.
    function automatic cmd_word_t random_event();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38)
            return make_cmd(MODE_STEER, int'($urandom_range(0, 200)) - 100);
        if (r < 66)
            return make_cmd(MODE_THROTTLE, $urandom_range(0, 100));
        if (r < 75)
            return make_cmd(MODE_THROTTLE, $urandom_range(0, 5));
        if (r < 86)
            return make_cmd(MODE_REVERSE, $urandom_range(0, 255));
        if (r < 90)
            return make_cmd(MODE_SPARE, $urandom_range(0, 255));
        if (r < 95)
            return make_cmd(MODE_STEER, $urandom_range(0, 255));
        return make_cmd(MODE_THROTTLE, $urandom_range(0, 255));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: saturating and deadzoned steering, throttle below, at
    // and above the floor, a refused and two accepted reverse presses, and
    // the spare code with both extreme axis bytes.
    task automatic test_reset_settings();
        send_event(make_cmd(MODE_STEER, 127));
        send_event(make_cmd(MODE_STEER, -128));
        send_event(make_cmd(MODE_STEER, 100));
        send_event(make_cmd(MODE_STEER, -100));
        send_event(make_cmd(MODE_STEER, 4));
        send_event(make_cmd(MODE_STEER, -5));
        send_event(make_cmd(MODE_STEER, 0));
        send_event(make_cmd(MODE_THROTTLE, 127));
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_REVERSE, 0));
        send_event(make_cmd(MODE_THROTTLE, -128));
        send_event(make_cmd(MODE_REVERSE, -1));
        send_event(make_cmd(MODE_THROTTLE, 1));
        send_event(make_cmd(MODE_THROTTLE, 2));
        send_event(make_cmd(MODE_REVERSE, 127));
        send_event(make_cmd(MODE_SPARE, 127));
        send_event(make_cmd(MODE_SPARE, -128));
        send_event(make_cmd(MODE_STEER, -60));
        send_event(make_cmd(MODE_THROTTLE, 80));
    endtask

    // Unity gain follows the input at once, zero gain never moves, and a
    // gain above unity must act as unity. A negative throttle is still below a
    // floor of zero and so zeroes the throttle.
    task automatic test_gain_extremes();
        program_regs(256, 0, 0, 0);
        send_event(make_cmd(MODE_STEER, -128));
        send_event(make_cmd(MODE_THROTTLE, -1));
        send_event(make_cmd(MODE_THROTTLE, 127));
        send_event(make_cmd(MODE_STEER, 50));
        send_event(make_cmd(MODE_STEER, -3));
        program_regs(0, 0, 0, 0);
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_STEER, 100));
        program_regs(511, 0, 0, 0);
        send_event(make_cmd(MODE_THROTTLE, 60));
        send_event(make_cmd(MODE_STEER, -60));
        program_regs(257, 3, 1, 2);
        send_event(make_cmd(MODE_STEER, 2));
        send_event(make_cmd(MODE_THROTTLE, 0));
    endtask

    // Deadzone and floor at their largest: all steering is zeroed, every
    // throttle sample zeroes the throttle, reverse is always taken, and the
    // widest update step keeps the held duties frozen; then at 100, then 0.
    task automatic test_large_thresholds();
        program_regs(128, 127, 127, 127);
        send_event(make_cmd(MODE_STEER, 100));
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_REVERSE, 0));
        send_event(make_cmd(MODE_STEER, -128));
        program_regs(256, 100, 100, 100);
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_STEER, 99));
        send_event(make_cmd(MODE_STEER, -100));
        send_event(make_cmd(MODE_REVERSE, 0));
        program_regs(256, 0, 0, 0);
        send_event(make_cmd(MODE_THROTTLE, 100));
        send_event(make_cmd(MODE_STEER, -100));
    endtask

    // Random events under a fresh random setting per phase. Idling on each
    // side is switched on and off in stretches so that some runs are packed
    // and gaps land on every cycle of the block's sequence.
    task automatic test_random_traffic(int phases, int per_phase);
        int gain;
        int deadzone;
        int floor_lvl;
        int delta;
        int r;
        for (int p = 0; p < phases; p++)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                gain = 256;
            else if (r < 22)
                gain = 0;
            else if (r < 32)
                gain = $urandom_range(257, 511);
            else
                gain = $urandom_range(1, 255);
            r = $urandom_range(0, 99);
            deadzone = (r < 10) ? 127 : $urandom_range(0, 20);
            r = $urandom_range(0, 99);
            if (r < 10)
                floor_lvl = $urandom_range(100, 127);
            else if (r < 20)
                floor_lvl = 0;
            else
                floor_lvl = $urandom_range(1, 30);
            r = $urandom_range(0, 99);
            if (r < 15)
                delta = 0;
            else if (r < 25)
                delta = $urandom_range(50, 127);
            else
                delta = $urandom_range(1, 6);
            program_regs(gain, deadzone, floor_lvl, delta);

            for (int i = 0; i < per_phase; i++)
            begin
                if (i % 40 == 0)
                begin
                    tx_idle_en = ($urandom_range(0, 3) != 0);
                    rx_idle_en = ($urandom_range(0, 3) != 0);
                end
                send_event(random_event());
            end
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // The receiver stops for a long stretch while words keep coming with no
    // gaps, so the output register fills and the command channel must stall.
    task automatic test_output_stall();
        program_regs(256, 0, 10, 0);
        tx_idle_en  = 1'b0;
        rx_hold_req = HOLD_OFF_LEN;
        for (int i = 0; i < 30; i++)
            send_event(random_event());
        tx_idle_en = 1'b1;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: ready with random gaps, plus a forced hold-off on request.
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        int hold;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold_req != 0)
            begin
                hold        = rx_hold_req;
                rx_hold_req = 0;
                repeat (hold) @(negedge clk) res_ready <= 1'b0;
            end
            else
            begin
                gap = rx_idle_en ? idle_gap() : 0;
                repeat (gap) @(negedge clk) res_ready <= 1'b0;
                @(negedge clk) res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check: every accepted word is compared with the oldest
    // prediction, field by field.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string why, res_word_t want, res_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t mismatch (%s): expected L=%0d R=%0d upd=%0b dl=%0b dr=%0b chg=%0b, got L=%0d R=%0d upd=%0b dl=%0b dr=%0b chg=%0b",
                     $realtime, why,
                     want.duty_left, want.duty_right, want.duty_updated,
                     want.dir_left, want.dir_right, want.dir_changed,
                     got.duty_left, got.duty_right, got.duty_updated,
                     got.dir_left, got.dir_right, got.dir_changed);
    endtask

    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (duty_words_due.size() == 0)
            begin
                report_mismatch("no word expected", '0, res);
            end
            else
            begin
                want = duty_words_due.pop_front();
                if (res.duty_left    !== want.duty_left    ||
                    res.duty_right   !== want.duty_right   ||
                    res.duty_updated !== want.duty_updated ||
                    res.dir_left     !== want.dir_left     ||
                    res.dir_right    !== want.dir_right    ||
                    res.dir_changed  !== want.dir_changed)
                    report_mismatch("field differs", want, res);
            end
        end
    end

    // Watchdog: any accepted word or register write restarts the count.
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        cmd_valid      = 1'b0;
        cmd            = '0;
        res_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_GAIN;
        cfg_data       = '0;
        mismatch_count = 0;
        quiet_cycles   = 0;
        tx_idle_en     = 1'b1;
        rx_idle_en     = 1'b1;
        rx_hold_req    = 0;
        reset_model();

        repeat (5) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_settings();
        test_gain_extremes();
        test_large_thresholds();
        test_random_traffic(6, 80);
        test_output_stall();

        // Let the last words drain, then give the block a short tail in
        // which any stray result word would still be caught.
        @(negedge clk) cmd_valid <= 1'b0;
        while (duty_words_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_count += duty_words_due.size();

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: smoothed_differential_drive_mixer_core.f
+incdir+design
design/sdm_pkg.sv
design/sdm_cfg_regs.sv
design/sdm_mul.sv
design/smoothed_differential_drive_mixer_core.sv
design/sdm_checker.sv
test/smoothed_differential_drive_mixer_core_tb.sv
